// ===== hdl/mpbm_pkg.sv =====
// Shared types and codes of the multi-pattern byte matcher.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package mpbm_pkg;

   localparam logic [2:0] KIND_SCAN    = 3'd0;
   localparam logic [2:0] KIND_RESTART = 3'd1;
   localparam logic [2:0] KIND_GOTO    = 3'd2;
   localparam logic [2:0] KIND_FAIL    = 3'd3;
   localparam logic [2:0] KIND_RANGE   = 3'd4;
   localparam logic [2:0] KIND_SLOT    = 3'd5;

   localparam logic [8:0] NO_EDGE = 9'd256;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_byte;
      logic [7:0] node;
      logic [8:0] target;
      logic [9:0] out_base;
      logic [3:0] out_count;
      logic [7:0] pattern_id;
   } req_item_type;

   typedef struct packed {
      logic        hit;
      logic [7:0]  match_pattern;
      logic [63:0] end_offset;
      logic        last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hdl/mpbm_ifs.sv =====
// Valid/ready channel interfaces of the matcher: request, response, control register.
// Depends on nothing.
`default_nettype none

interface mpbm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data_byte;
   logic [7:0] node;
   logic [8:0] target;
   logic [9:0] out_base;
   logic [3:0] out_count;
   logic [7:0] pattern_id;
   modport source (output valid, kind, data_byte, node, target, out_base, out_count,
                   pattern_id, input ready);
   modport sink (input valid, kind, data_byte, node, target, out_base, out_count,
                 pattern_id, output ready);
endinterface

interface mpbm_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [7:0]  match_pattern;
   logic [63:0] end_offset;
   logic        last;
   modport source (output valid, hit, match_pattern, end_offset, last, input ready);
   modport sink (input valid, hit, match_pattern, end_offset, last, output ready);
endinterface

interface mpbm_csr_if;
   logic valid;
   logic ready;
   logic stop_on_hit;
   modport source (output valid, stop_on_hit, input ready);
   modport sink (input valid, stop_on_hit, output ready);
endinterface

`default_nettype wire

// ===== hdl/mpbm_tables.sv =====
// Goto, failure, output range and output slot memories of the matcher.
// Depends on mpbm_pkg for the item type and kind codes.
`default_nettype none

module mpbm_tables #(
   parameter int NODES         = 256,
   parameter int ALPHABET_SIZE = 256,
   parameter int OUT_SLOTS     = 1024,
   parameter int PATTERNS      = 256
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire mpbm_pkg::req_item_type  wr_item,
   input  wire logic [$clog2(NODES)+$clog2(ALPHABET_SIZE)-1:0] goto_raddr,
   input  wire logic [$clog2(NODES)-1:0] fail_raddr,
   input  wire logic [$clog2(NODES)-1:0] range_raddr,
   input  wire logic [$clog2(OUT_SLOTS)-1:0] slot_raddr,
   output logic                         goto_valid,
   output logic [$clog2(NODES)-1:0]     goto_node,
   output logic [$clog2(NODES)-1:0]     fail_node,
   output logic [9:0]                   range_base,
   output logic [3:0]                   range_count,
   output logic [7:0]                   slot_pat
);
   localparam int NW = $clog2(NODES);
   localparam int AW = $clog2(ALPHABET_SIZE);
   localparam int GW = NW + AW;
   localparam int SW = $clog2(OUT_SLOTS);

   logic [NW:0]   goto_mem  [0:(1 << GW)-1];
   logic [NW-1:0] fail_mem  [0:NODES-1];
   logic [13:0]   range_mem [0:NODES-1];
   logic [7:0]    slot_mem  [0:OUT_SLOTS-1];

   logic node_ok, byte_ok, tgt_ok, slot_ok;

   assign node_ok = 32'(wr_item.node) < NODES;
   assign byte_ok = 32'(wr_item.data_byte) < ALPHABET_SIZE;
   assign tgt_ok  = (32'(wr_item.target) < NODES) && (wr_item.target != mpbm_pkg::NO_EDGE);
   assign slot_ok = (32'(wr_item.out_base) < OUT_SLOTS) &&
                    (32'(wr_item.pattern_id) < PATTERNS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_item.kind)
            mpbm_pkg::KIND_GOTO: begin
               if (node_ok && byte_ok) begin
                  goto_mem[{NW'(wr_item.node), AW'(wr_item.data_byte)}] <=
                     tgt_ok ? {1'b1, NW'(wr_item.target)} : '0;
               end
            end
            mpbm_pkg::KIND_FAIL: begin
               if (node_ok) begin
                  fail_mem[NW'(wr_item.node)] <=
                     (32'(wr_item.target) < NODES) ? NW'(wr_item.target) : '0;
               end
            end
            mpbm_pkg::KIND_RANGE: begin
               if (node_ok) begin
                  range_mem[NW'(wr_item.node)] <= {wr_item.out_base, wr_item.out_count};
               end
            end
            mpbm_pkg::KIND_SLOT: begin
               if (slot_ok) begin
                  slot_mem[SW'(wr_item.out_base)] <= wr_item.pattern_id;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      {goto_valid, goto_node}   <= goto_mem[goto_raddr];
      fail_node                 <= fail_mem[fail_raddr];
      {range_base, range_count} <= range_mem[range_raddr];
      slot_pat                  <= slot_mem[slot_raddr];
   end

endmodule

`default_nettype wire

// ===== hdl/mpbm_seq.sv =====
// Scan sequencer: failure-link walk, output list emission and result register.
// Depends on mpbm_pkg; drives the read ports of mpbm_tables.
`default_nettype none

module mpbm_seq #(
   parameter int NODES         = 256,
   parameter int ALPHABET_SIZE = 256,
   parameter int OUT_SLOTS     = 1024,
   parameter int MAX_OUT       = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    stop_on_hit,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire mpbm_pkg::req_item_type  in_item,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output mpbm_pkg::rsp_item_type       out_item,
   output logic                         tbl_wr_en,
   output logic [$clog2(NODES)+$clog2(ALPHABET_SIZE)-1:0] goto_raddr,
   output logic [$clog2(NODES)-1:0]     fail_raddr,
   output logic [$clog2(NODES)-1:0]     range_raddr,
   output logic [$clog2(OUT_SLOTS)-1:0] slot_raddr,
   input  wire logic                    goto_valid,
   input  wire logic [$clog2(NODES)-1:0] goto_node,
   input  wire logic [$clog2(NODES)-1:0] fail_node,
   input  wire logic [9:0]              range_base,
   input  wire logic [3:0]              range_count,
   input  wire logic [7:0]              slot_pat
);
   localparam int NW = $clog2(NODES);
   localparam int AW = $clog2(ALPHABET_SIZE);
   localparam int SW = $clog2(OUT_SLOTS);
   localparam int PW = (SW > 10) ? SW : 10;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_WALK    = 7'b0000010,
      S_RANGE   = 7'b0000100,
      S_REDUCE  = 7'b0001000,
      S_SLOT_RD = 7'b0010000,
      S_SLOT    = 7'b0100000,
      S_EMPTY   = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [NW-1:0]           node_ff, node_in;
   logic [NW-1:0]           look_ff, look_in;
   logic [7:0]              byte_ff, byte_in;
   logic [NW:0]             steps_ff, steps_in;
   logic [63:0]             offset_ff, offset_in;
   logic                    frozen_ff, frozen_in;
   logic [PW-1:0]           ptr_ff, ptr_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [3:0]              k_ff, k_in;
   logic                    out_valid_ff, out_valid_in;
   mpbm_pkg::rsp_item_type  out_item_ff, out_item_in;

   logic          accept, out_free, edge_ok, last_res;
   logic [PW:0]   ptr_next;

   assign accept    = in_valid && in_ready;
   assign in_ready  = (state_ff == S_IDLE);
   assign tbl_wr_en = accept;
   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
   assign edge_ok   = goto_valid && (32'(byte_ff) < ALPHABET_SIZE);
   assign last_res  = stop_on_hit || ((k_ff + 4'd1) == cnt_ff);
   assign ptr_next  = (PW+1)'(ptr_ff) + (PW+1)'(1);

   assign goto_raddr  = {look_in, AW'(byte_in)};
   assign fail_raddr  = look_in;
   assign range_raddr = look_in;
   assign slot_raddr  = SW'(ptr_in);

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      look_in      = look_ff;
      byte_in      = byte_ff;
      steps_in     = steps_ff;
      offset_in    = offset_ff;
      frozen_in    = frozen_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_item_in  = out_item_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (in_item.kind)
                  mpbm_pkg::KIND_SCAN: begin
                     if (!frozen_ff) begin
                        look_in  = node_ff;
                        byte_in  = in_item.data_byte;
                        steps_in = '0;
                        state_in = S_WALK;
                     end
                  end
                  mpbm_pkg::KIND_RESTART: begin
                     node_in   = '0;
                     offset_in = '0;
                     frozen_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (edge_ok || (look_ff == '0)) begin
               node_in  = edge_ok ? goto_node : '0;
               look_in  = node_in;
               state_in = S_RANGE;
            end else if (steps_ff == (NW+1)'(NODES)) begin
               look_in = '0;
            end else begin
               look_in  = fail_node;
               steps_in = steps_ff + (NW+1)'(1);
            end
         end
         S_RANGE: begin
            ptr_in = PW'(range_base);
            cnt_in = (32'(range_count) > MAX_OUT) ? 4'(MAX_OUT) : range_count;
            k_in   = '0;
            state_in = (cnt_in == '0) ? S_EMPTY : S_REDUCE;
         end
         S_REDUCE: begin
            if (32'(ptr_ff) >= OUT_SLOTS) begin
               ptr_in = ptr_ff - PW'(OUT_SLOTS);
            end else begin
               state_in = S_SLOT;
            end
         end
         S_SLOT_RD: begin
            state_in = S_SLOT;
         end
         S_SLOT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_item_in  = '{hit: 1'b1, match_pattern: slot_pat,
                                end_offset: offset_ff, last: last_res};
               if (last_res) begin
                  offset_in = offset_ff + 64'd1;
                  frozen_in = stop_on_hit;
                  state_in  = S_IDLE;
               end else begin
                  ptr_in   = (32'(ptr_next) == OUT_SLOTS) ? '0 : PW'(ptr_next);
                  k_in     = k_ff + 4'd1;
                  state_in = S_SLOT_RD;
               end
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_item_in  = '{hit: 1'b0, match_pattern: 8'd0,
                                end_offset: offset_ff, last: 1'b1};
               offset_in    = offset_ff + 64'd1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         node_ff      <= '0;
         offset_ff    <= '0;
         frozen_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         offset_ff    <= offset_in;
         frozen_ff    <= frozen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      look_ff     <= look_in;
      byte_ff     <= byte_in;
      steps_ff    <= steps_in;
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      out_item_ff <= out_item_in;
   end

endmodule

`default_nettype wire

// ===== hdl/multi_pattern_byte_matcher.sv =====
// Top level of the multi-pattern byte matcher: control register, sequencer and tables.
// Depends on mpbm_pkg, mpbm_ifs, mpbm_tables and mpbm_seq.
//
// Aho-Corasick matcher over loaded goto, failure, output range and output slot
// memories. Load items, restarts and scan bytes ignored while frozen take one
// cycle. A scan byte follows failure links (one memory read per link, at most
// NODES, after which the walk falls back to the root), reads the node's output
// range, subtracts OUT_SLOTS from the base slot until it is below OUT_SLOTS and
// then reads one slot per result given; a scan byte with no hit gives one miss
// item. No new item is taken until the last result of a scan byte is registered
// for output, and output stalls hold the sequencer.
// Unwritten memory entries read as undefined; load every entry before scanning.
`default_nettype none

module multi_pattern_byte_matcher #(
   parameter int NODES         = 256,
   parameter int ALPHABET_SIZE = 256,
   parameter int OUT_SLOTS     = 1024,
   parameter int MAX_OUT       = 8,
   parameter int PATTERNS      = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   mpbm_req_if.sink   req,
   mpbm_rsp_if.source rsp,
   mpbm_csr_if.sink   csr
);
   localparam int NW = $clog2(NODES);
   localparam int AW = $clog2(ALPHABET_SIZE);
   localparam int SW = $clog2(OUT_SLOTS);

   logic                    stop_on_hit_ff, stop_on_hit_in;
   mpbm_pkg::req_item_type  in_item;
   mpbm_pkg::rsp_item_type  out_item;
   logic                    tbl_wr_en, goto_valid;
   logic [NW+AW-1:0]        goto_raddr;
   logic [NW-1:0]           fail_raddr, range_raddr, goto_node, fail_node;
   logic [SW-1:0]           slot_raddr;
   logic [9:0]              range_base;
   logic [3:0]              range_count;
   logic [7:0]              slot_pat;

   assign csr.ready      = 1'b1;
   assign stop_on_hit_in = (csr.valid && csr.ready) ? csr.stop_on_hit : stop_on_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_on_hit_ff <= 1'b1;
      end else begin
         stop_on_hit_ff <= stop_on_hit_in;
      end
   end

   assign in_item = '{kind: req.kind, data_byte: req.data_byte, node: req.node,
                      target: req.target, out_base: req.out_base,
                      out_count: req.out_count, pattern_id: req.pattern_id};

   assign rsp.hit           = out_item.hit;
   assign rsp.match_pattern = out_item.match_pattern;
   assign rsp.end_offset    = out_item.end_offset;
   assign rsp.last          = out_item.last;

   mpbm_seq #(
      .NODES(NODES), .ALPHABET_SIZE(ALPHABET_SIZE), .OUT_SLOTS(OUT_SLOTS),
      .MAX_OUT(MAX_OUT)
   ) u_seq (
      .clock(clock), .reset(reset), .stop_on_hit(stop_on_hit_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_item(in_item),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_item(out_item),
      .tbl_wr_en(tbl_wr_en), .goto_raddr(goto_raddr), .fail_raddr(fail_raddr),
      .range_raddr(range_raddr), .slot_raddr(slot_raddr),
      .goto_valid(goto_valid), .goto_node(goto_node), .fail_node(fail_node),
      .range_base(range_base), .range_count(range_count), .slot_pat(slot_pat)
   );

   mpbm_tables #(
      .NODES(NODES), .ALPHABET_SIZE(ALPHABET_SIZE), .OUT_SLOTS(OUT_SLOTS),
      .PATTERNS(PATTERNS)
   ) u_tables (
      .clock(clock), .wr_en(tbl_wr_en), .wr_item(in_item),
      .goto_raddr(goto_raddr), .fail_raddr(fail_raddr),
      .range_raddr(range_raddr), .slot_raddr(slot_raddr),
      .goto_valid(goto_valid), .goto_node(goto_node), .fail_node(fail_node),
      .range_base(range_base), .range_count(range_count), .slot_pat(slot_pat)
   );

endmodule

`default_nettype wire

// ===== hdl/mpbm_chk.sv =====
// Port-level checker for the matcher and its bind to the top level.
// Depends on the top level's port names only.
`default_nettype none

module mpbm_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit,
   input wire logic [7:0]  rsp_match_pattern,
   input wire logic [63:0] rsp_end_offset,
   input wire logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_match_pattern) && $stable(rsp_end_offset) && $stable(rsp_last))
      else $error("stalled item changed");

   a_busy_mid_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a result list");

   a_miss_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_last && (rsp_match_pattern == 8'd0))
      else $error("miss item not alone or with a pattern");

   a_same_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
      !rsp_valid || (rsp_end_offset == $past(rsp_end_offset)))
      else $error("offset changed within one result list");

endmodule

bind multi_pattern_byte_matcher mpbm_chk u_chk (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
   .rsp_match_pattern(rsp.match_pattern), .rsp_end_offset(rsp.end_offset),
   .rsp_last(rsp.last)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of multi_pattern_byte_matcher: loads a small trie, then scans bytes.
// Depends on mpbm_pkg and mpbm_ifs; checks every result against its own matcher prediction.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int USED_NODES = 8;
   localparam int SLOTS      = 1024;
   localparam int LOAD_SLOTS = 32;
   localparam int MAX_HITS   = 8;
   localparam int WDOG_LIMIT = 5000;
   localparam int SETTLE     = 300;
   localparam int N_SCAN_SET = 8;
   localparam int REQ_W      = $bits(mpbm_pkg::req_item_type);
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;
   localparam logic [7:0] SCAN_SET [N_SCAN_SET] =
      '{8'h00, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h7E, 8'hFF};

   logic clock;
   logic reset;

   mpbm_req_if req_ch ();
   mpbm_rsp_if rsp_ch ();
   mpbm_csr_if csr_ch ();

   multi_pattern_byte_matcher DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   // matcher state as predicted
   logic [8:0]  edge_dest [256][256];
   bit          edge_ok   [256][256];
   logic [7:0]  fail_link [256];
   logic [9:0]  list_base [256];
   logic [3:0]  list_len  [256];
   logic [7:0]  slot_pat  [SLOTS];
   logic [7:0]  cur_node;
   logic [63:0] offset;
   bit          frozen;
   bit          stop_mode;

   mpbm_pkg::req_item_type pend_items [$];
   mpbm_pkg::rsp_item_type match_q    [$];
   mpbm_pkg::req_item_type cur_item;

   longint cyc;
   int     items_sent, results_seen, hits_seen, errors, mismatches, phases_run;
   int     idle_cnt;
   bit     holdoff_done;
   int     holdoff_cnt;

   function automatic bit no_gap();
      return (cyc % 4000) < 600;
   endfunction

   task automatic queue_req(input mpbm_pkg::req_item_type it);
      pend_items = {pend_items, it};
   endtask

   task automatic queue_rsp(input mpbm_pkg::rsp_item_type r);
      match_q = {match_q, r};
   endtask

   task automatic scan_predict(input logic [7:0] b);
      logic [7:0]   n;
      int           steps, cnt;
      logic [9:0]   base;
      mpbm_pkg::rsp_item_type r;
      n = cur_node;
      steps = 0;
      while (n != 0 && !edge_ok[n][b] && steps < 256) begin
         n = fail_link[n];
         steps++;
      end
      if (n != 0 && !edge_ok[n][b]) n = 0;
      if (edge_ok[n][b]) n = edge_dest[n][b][7:0];
      else n = 0;
      cur_node = n;
      cnt = list_len[n];
      base = list_base[n];
      if (cnt > MAX_HITS) cnt = MAX_HITS;
      if (cnt == 0) begin
         r = '{hit: 1'b0, match_pattern: 8'd0, end_offset: offset, last: 1'b1};
         queue_rsp(r);
      end else if (stop_mode) begin
         r = '{hit: 1'b1, match_pattern: slot_pat[base], end_offset: offset, last: 1'b1};
         queue_rsp(r);
         frozen = 1;
      end else begin
         for (int k = 0; k < cnt; k++) begin
            r.hit = 1'b1;
            r.match_pattern = slot_pat[(base + k) % SLOTS];
            r.end_offset = offset;
            r.last = (k + 1 == cnt);
            queue_rsp(r);
         end
      end
      offset++;
   endtask

   task automatic apply_item(input mpbm_pkg::req_item_type it);
      case (it.kind)
         mpbm_pkg::KIND_SCAN: if (!frozen) scan_predict(it.data_byte);
         mpbm_pkg::KIND_RESTART: begin
            cur_node = 0;
            offset = 0;
            frozen = 0;
         end
         mpbm_pkg::KIND_GOTO: begin
            edge_ok[it.node][it.data_byte] = (it.target < mpbm_pkg::NO_EDGE);
            edge_dest[it.node][it.data_byte] =
               (it.target < mpbm_pkg::NO_EDGE) ? it.target : 9'd0;
         end
         mpbm_pkg::KIND_FAIL:
            fail_link[it.node] = (it.target < mpbm_pkg::NO_EDGE) ? it.target[7:0] : 8'd0;
         mpbm_pkg::KIND_RANGE: begin
            list_base[it.node] = it.out_base;
            list_len[it.node] = it.out_count;
         end
         mpbm_pkg::KIND_SLOT: slot_pat[it.out_base] = it.pattern_id;
         default: ;
      endcase
   endtask

   function automatic mpbm_pkg::req_item_type mk(input logic [2:0] k, input logic [7:0] b,
                                                 input logic [7:0] n, input logic [8:0] t,
                                                 input logic [9:0] ob, input logic [3:0] oc,
                                                 input logic [7:0] p);
      mpbm_pkg::req_item_type it;
      it = '{kind: k, data_byte: b, node: n, target: t, out_base: ob, out_count: oc,
             pattern_id: p};
      return it;
   endfunction

   // destination inside the loaded node set, or a missing edge / root
   function automatic logic [8:0] safe_target(input int miss_pct);
      if ($urandom_range(0, 99) < miss_pct) return 9'(256 + $urandom_range(0, 255));
      return 9'($urandom_range(0, USED_NODES - 1));
   endfunction

   // first slot of a list that stays inside the loaded slots
   function automatic logic [9:0] safe_base();
      return 10'($urandom_range(0, LOAD_SLOTS - MAX_HITS));
   endfunction

   function automatic mpbm_pkg::req_item_type rand_item(input bit stop);
      mpbm_pkg::req_item_type it;
      int                     sel;
      it = mpbm_pkg::req_item_type'(REQ_W'({$urandom, $urandom}));
      it.node = 8'($urandom_range(0, USED_NODES - 1));
      sel = $urandom_range(0, 99);
      if (sel < (stop ? 62 : 70)) begin
         it.kind = mpbm_pkg::KIND_SCAN;
         it.data_byte = SCAN_SET[$urandom_range(0, N_SCAN_SET - 1)];
      end else if (sel < 75) it.kind = mpbm_pkg::KIND_RESTART;
      else if (sel < 82) begin
         it.kind = mpbm_pkg::KIND_GOTO;
         it.target = safe_target(60);
      end else if (sel < 86) begin
         it.kind = mpbm_pkg::KIND_FAIL;
         it.target = safe_target(40);
      end else if (sel < 91) begin
         it.kind = mpbm_pkg::KIND_RANGE;
         it.out_base = safe_base();
      end else if (sel < 95) it.kind = mpbm_pkg::KIND_SLOT;
      else if (sel < 98) begin
         it.kind = 3'($urandom_range(mpbm_pkg::KIND_GOTO, mpbm_pkg::KIND_RANGE));
         it.node = 8'($urandom_range(USED_NODES, 255));
      end else it.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
      return it;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pend_items.size() != 0 || req_ch.valid || match_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_stop(input bit v);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.stop_on_hit <= v;
      forever begin
         @(posedge clock);
         if (csr_ch.ready) break;
      end
      stop_mode = v;
      csr_ch.valid <= 1'b0;
      phases_run++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cyc <= cyc + 1;

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_item(cur_item);
            items_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pend_items.size() != 0 && (no_gap() || $urandom_range(0, 99) >= 36)) begin
               cur_item = pend_items.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.kind       <= cur_item.kind;
               req_ch.data_byte  <= cur_item.data_byte;
               req_ch.node       <= cur_item.node;
               req_ch.target     <= cur_item.target;
               req_ch.out_base   <= cur_item.out_base;
               req_ch.out_count  <= cur_item.out_count;
               req_ch.pattern_id <= cur_item.pattern_id;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      mpbm_pkg::rsp_item_type e;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.hit) hits_seen++;
            if (match_q.size() == 0) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: unexpected result hit=%0b pat=%0d off=%0d last=%0b",
                           rsp_ch.hit, rsp_ch.match_pattern, rsp_ch.end_offset, rsp_ch.last);
            end else begin
               e = match_q.pop_front();
               if (rsp_ch.hit !== e.hit || rsp_ch.match_pattern !== e.match_pattern ||
                   rsp_ch.end_offset !== e.end_offset || rsp_ch.last !== e.last) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"tb: mismatch exp hit=%0b pat=%0d off=%0d last=%0b, ",
                               "got hit=%0b pat=%0d off=%0d last=%0b"},
                              e.hit, e.match_pattern, e.end_offset, e.last, rsp_ch.hit,
                              rsp_ch.match_pattern, rsp_ch.end_offset, rsp_ch.last);
               end
            end
         end
         if (!holdoff_done && results_seen >= 20) begin
            holdoff_done <= 1'b1;
            holdoff_cnt <= 400;
            rsp_ch.ready <= 1'b0;
         end else if (holdoff_cnt > 0) begin
            holdoff_cnt <= holdoff_cnt - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_gap() || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cnt <= 0;
      end else begin
         idle_cnt <= idle_cnt + 1;
         if (idle_cnt >= WDOG_LIMIT) begin
            $display("tb: watchdog expired");
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int n_rand;
      bit modes [4];
      reset = 1'b1;
      cyc = 0;
      req_ch.valid = 1'b0;
      req_ch.kind = mpbm_pkg::KIND_SCAN;
      req_ch.data_byte = '0;
      req_ch.node = '0;
      req_ch.target = '0;
      req_ch.out_base = '0;
      req_ch.out_count = '0;
      req_ch.pattern_id = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.stop_on_hit = 1'b1;
      items_sent = 0; results_seen = 0; hits_seen = 0; errors = 0; mismatches = 0;
      phases_run = 0; idle_cnt = 0; holdoff_done = 0; holdoff_cnt = 0;
      cur_node = 0; offset = 0; frozen = 0; stop_mode = 1;
      for (int i = 0; i < 256; i++) begin
         fail_link[i] = 0; list_base[i] = 0; list_len[i] = 0;
         for (int j = 0; j < 256; j++) begin
            edge_dest[i][j] = 0;
            edge_ok[i][j] = 1;
         end
      end
      for (int i = 0; i < SLOTS; i++) slot_pat[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_stop(1'b1);
      for (int n = 0; n < USED_NODES; n++) begin
         for (int b = 0; b < N_SCAN_SET; b++)
            queue_req(mk(mpbm_pkg::KIND_GOTO, SCAN_SET[b], 8'(n), safe_target(70),
                         '0, '0, '0));
         queue_req(mk(mpbm_pkg::KIND_FAIL, '0, 8'(n), safe_target(30), '0, '0, '0));
         queue_req(mk(mpbm_pkg::KIND_RANGE, '0, 8'(n), '0, safe_base(),
                      4'($urandom_range(0, 15)), '0));
      end
      for (int s = 0; s < LOAD_SLOTS; s++)
         queue_req(mk(mpbm_pkg::KIND_SLOT, '0, '0, '0, 10'(s), '0, 8'($urandom)));

      queue_req(mk(mpbm_pkg::KIND_RANGE, '0, 8'd0, '0, 10'd0, 4'd0, '0));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h00, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'hFF, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_GOTO, 8'h41, 8'd0, 9'd3, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_RANGE, '0, 8'd3, '0, 10'd1023, 4'd15, '0));
      queue_req(mk(mpbm_pkg::KIND_SLOT, '0, '0, '0, 10'd1023, 4'd0, 8'hFF));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h41, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h41, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_RESTART, '0, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_FAIL, '0, 8'd3, 9'd3, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_GOTO, 8'h42, 8'd3, 9'h1FF, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h41, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_GOTO, 8'hFF, 8'hFF, 9'h0FF, 10'h3FF, 4'hF, 8'hFF));
      queue_req(mk(mpbm_pkg::KIND_FAIL, '0, 8'hFF, 9'h1FF, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_RANGE, '0, 8'hFF, '0, 10'h3FF, 4'hF, '0));
      queue_req(mk(KIND_SPARE_A, 8'h41, '0, '0, '0, '0, '0));
      queue_req(mk(KIND_SPARE_B, 8'h41, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_RESTART, '0, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h42, '0, '0, '0, '0, '0));
      wait_idle();

      write_stop(1'b0);
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h41, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h42, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_RESTART, '0, '0, '0, '0, '0, '0));
      queue_req(mk(mpbm_pkg::KIND_SCAN, 8'h41, '0, '0, '0, '0, '0));
      wait_idle();

      modes = '{1'b1, 1'b0, 1'b1, 1'b0};
      for (int p = 0; p < 4; p++) begin
         write_stop(modes[p]);
         n_rand = 32;
         for (int i = 0; i < n_rand; i++) queue_req(rand_item(modes[p]));
         wait_idle();
      end

      $display("tb: %0d items sent over %0d register settings, %0d results (%0d hits) checked",
               items_sent, phases_run, results_seen, hits_seen);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d mismatches", mismatches);
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== sim.f =====
hdl/mpbm_pkg.sv
hdl/mpbm_ifs.sv
hdl/mpbm_tables.sv
hdl/mpbm_seq.sv
hdl/multi_pattern_byte_matcher.sv
hdl/mpbm_chk.sv
dv/tb.sv
